@@ rtl/core/multithread_core_thread_scheduler_defines.svh @@
// Assertion macros for the multithreaded core scheduler.
// Included by the top level; expects i_clk and i_rst_n in scope.
`ifndef MULTITHREAD_CORE_THREAD_SCHEDULER_DEFINES_SVH
`define MULTITHREAD_CORE_THREAD_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
// Implication in the same cycle.
`define MTS_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error("mts assertion failed");
// Implication into the next cycle.
`define MTS_ASSERT_NXT(lbl, ante, cons) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error("mts assertion failed");
`else
`define MTS_ASSERT_IMP(lbl, ante, cons)
`define MTS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/mts_pkg.sv @@
// Shared types and constants of the multithreaded core scheduler.
// Used by the controller, the datapath and the top level; no dependencies.
package mts_pkg;

    localparam int THREADS_MAX = 8;
    localparam int REGISTERS   = 8;
    localparam int RF_DEPTH    = THREADS_MAX * REGISTERS;
    localparam int RF_AW       = $clog2(RF_DEPTH);

    // Instruction codes.
    typedef enum logic [2:0] {
        OPC_NOP, OPC_ADD, OPC_SUB, OPC_ADDI, OPC_SUBI, OPC_LOAD, OPC_STORE, OPC_HALT
    } t_opcode;

    // Item kinds.
    typedef enum logic [1:0] {
        MODE_INSTR, MODE_LOAD_RET, MODE_CTX_READ, MODE_NONE
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_POLICY, CFG_ACTIVE, CFG_LOAD_LAT, CFG_STORE_LAT, CFG_SWITCH_OVH
    } t_cfg_index;

    // Input beat.
    typedef struct packed {
        logic [1:0]         mode;
        logic [2:0]         opcode;
        logic [2:0]         dest_reg;
        logic [2:0]         src_reg;
        logic signed [31:0] src2_value;
        logic               src2_is_imm;
        logic signed [31:0] load_data;
        logic [2:0]         query_thread;
        logic [2:0]         query_reg;
    } t_item;

    // Result beat.
    typedef struct packed {
        logic               fetch_ready;
        logic [2:0]         next_thread;
        logic [31:0]        next_pc;
        logic               mem_read;
        logic               mem_write;
        logic signed [31:0] mem_address;
        logic signed [31:0] mem_write_data;
        logic signed [31:0] read_data;
        logic [31:0]        cycle_count;
        logic [31:0]        instruction_count;
        logic               all_halted;
    } t_res;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE, S_RD_A, S_RD_B, S_RD_C, S_EXEC, S_SCH_MIN, S_SCH_PICK,
        S_SCH_SWITCH, S_LOAD_RET, S_CTX, S_FIN
    } t_state;

    // Datapath operations.
    typedef enum logic [3:0] {
        DP_NONE, DP_LATCH, DP_RD_A, DP_RD_B, DP_RD_C, DP_EXEC, DP_SCH_MIN,
        DP_SCH_PICK, DP_SCH_SWITCH, DP_LOAD_RET, DP_CTX, DP_FIN
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic all_halted;
        logic need_sched;
        logic out_busy;
    } t_dp_status;

endpackage

@@ rtl/core/mts_datapath.sv @@
// Datapath of the scheduler: contexts, register file, timers, counters, result register.
// Depends on mts_pkg; driven by mts_ctrl through t_dp_cmd.
module mts_datapath import mts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item       i_item,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output t_res        o_result,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Configuration registers.
    logic        r_policy;
    logic [3:0]  r_active;
    logic [15:0] r_load_lat, r_store_lat, r_switch_ovh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy     <= 1'b0;
            r_active     <= 4'd8;
            r_load_lat   <= 16'd4;
            r_store_lat  <= 16'd4;
            r_switch_ovh <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_POLICY:     r_policy     <= i_cfg_data[0];
                CFG_ACTIVE:     r_active     <= i_cfg_data[3:0];
                CFG_LOAD_LAT:   r_load_lat   <= i_cfg_data;
                CFG_STORE_LAT:  r_store_lat  <= i_cfg_data;
                CFG_SWITCH_OVH: r_switch_ovh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Thread contexts and scheduler state.
    logic [31:0] r_pc [THREADS_MAX];
    logic [31:0] n_pc [THREADS_MAX];
    logic [15:0] r_timer [THREADS_MAX];
    logic [15:0] n_timer [THREADS_MAX];
    logic [31:0] r_last [THREADS_MAX];
    logic [31:0] n_last [THREADS_MAX];
    logic [THREADS_MAX-1:0] r_idle, n_idle, r_halted, n_halted;
    logic [2:0]  r_cur, n_cur, r_next, n_next;
    logic [31:0] r_cyc, n_cyc, r_inst, n_inst;
    logic        r_ld_pend, n_ld_pend;
    logic [2:0]  r_ld_target, n_ld_target, r_ld_thread, n_ld_thread;
    logic        r_all_idle, n_all_idle, r_skip, n_skip;
    logic [15:0] r_least, n_least;

    // Per-item working registers.
    t_item       r_in, n_in;
    logic [31:0] r_opa, n_opa, r_opb, n_opb;
    logic        r_mrd, n_mrd, r_mwr, n_mwr;
    logic [31:0] r_addr, n_addr, r_wdata, n_wdata;
    t_res        r_out, n_out;
    logic        r_out_valid, n_out_valid;

    // Effective thread count and halt status.
    logic [3:0] live_n;
    logic       every_halted;

    always_comb begin
        if (r_active == 4'd0) begin
            live_n = 4'd1;
        end else if (r_active > 4'(THREADS_MAX)) begin
            live_n = 4'(THREADS_MAX);
        end else begin
            live_n = r_active;
        end
        every_halted = 1'b1;
        for (int i = 0; i < THREADS_MAX; i++) begin
            if (i < int'(live_n) && !r_halted[i]) every_halted = 1'b0;
        end
    end

    // Register file memory, one read and one write port, with valid bits.
    logic [31:0]        rf_mem [RF_DEPTH];
    logic [RF_DEPTH-1:0] r_rf_valid;
    logic [31:0]        r_rf_q;
    logic               r_rf_qv, r_rf_inr;
    logic [RF_AW-1:0]   rf_raddr, rf_waddr;
    logic [31:0]        rf_wdata, rf_out;
    logic               rf_we, rd_inr;

    always_comb begin
        rd_inr = 1'b1;
        unique case (i_cmd.op)
            DP_RD_A: rf_raddr = {r_cur, (r_in.opcode == OPC_STORE) ? r_in.dest_reg
                                                                     : r_in.src_reg};
            DP_RD_B: begin
                rf_raddr = {r_cur, r_in.src2_value[2:0]};
                rd_inr   = $unsigned(r_in.src2_value) < 32'(REGISTERS);
            end
            DP_RD_C: rf_raddr = {r_cur, r_in.src_reg};
            default: rf_raddr = {r_in.query_thread, r_in.query_reg};
        endcase
        rf_out = (r_rf_qv && r_rf_inr) ? r_rf_q : 32'd0;
    end

    // Write port: arithmetic results and returned load data.
    always_comb begin
        rf_we    = 1'b0;
        rf_waddr = {r_cur, r_in.dest_reg};
        rf_wdata = 32'd0;
        if (i_cmd.op == DP_EXEC) begin
            unique case (r_in.opcode)
                OPC_ADD:  begin rf_we = 1'b1; rf_wdata = r_opa + r_opb; end
                OPC_SUB:  begin rf_we = 1'b1; rf_wdata = r_opa - r_opb; end
                OPC_ADDI: begin rf_we = 1'b1; rf_wdata = r_opa + r_in.src2_value; end
                OPC_SUBI: begin rf_we = 1'b1; rf_wdata = r_opa - r_in.src2_value; end
                default:  rf_we = 1'b0;
            endcase
        end else if (i_cmd.op == DP_LOAD_RET && r_ld_pend) begin
            rf_we    = 1'b1;
            rf_waddr = {r_ld_thread, r_ld_target};
            rf_wdata = r_in.load_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
        r_rf_q <= rf_mem[rf_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_valid <= '0;
            r_rf_qv    <= 1'b0;
            r_rf_inr   <= 1'b0;
        end else begin
            if (rf_we) r_rf_valid[rf_waddr] <= 1'b1;
            r_rf_qv  <= r_rf_valid[rf_raddr];
            r_rf_inr <= rd_inr;
        end
    end

    // Next-state logic for every step of the datapath.
    always_comb begin
        logic [31:0] bval;
        logic        found;
        logic        cand;
        logic [2:0]  pick;
        logic [15:0] diff;
        n_pc = r_pc; n_timer = r_timer; n_last = r_last;
        n_idle = r_idle; n_halted = r_halted; n_cur = r_cur; n_next = r_next;
        n_cyc = r_cyc; n_inst = r_inst; n_ld_pend = r_ld_pend;
        n_ld_target = r_ld_target; n_ld_thread = r_ld_thread;
        n_all_idle = r_all_idle; n_skip = r_skip; n_least = r_least;
        n_in = r_in; n_opa = r_opa; n_opb = r_opb;
        n_mrd = r_mrd; n_mwr = r_mwr; n_addr = r_addr; n_wdata = r_wdata;
        n_out = r_out;
        bval = r_in.src2_is_imm ? r_in.src2_value : r_opb;
        found = 1'b0; cand = 1'b0; pick = r_cur; diff = 16'd0;
        unique case (i_cmd.op)
            DP_LATCH: begin
                n_in = i_item;
                n_mrd = 1'b0; n_mwr = 1'b0; n_addr = 32'd0; n_wdata = 32'd0;
            end
            DP_RD_B: n_opa = rf_out;
            DP_RD_C: n_opb = rf_out;
            DP_EXEC: begin
                // Count the instruction, stamp and advance the current thread.
                n_cyc  = r_cyc + 32'd1;
                n_inst = r_inst + 32'd1;
                n_last[r_cur] = r_cyc + 32'd1;
                n_pc[r_cur]   = r_pc[r_cur] + 32'd1;
                // Age the timer of every running thread by one.
                for (int i = 0; i < THREADS_MAX; i++) begin
                    if (i < int'(live_n) && !r_halted[i]) begin
                        if (r_timer[i] <= 16'd1) begin
                            n_timer[i] = 16'd0;
                            n_idle[i]  = 1'b0;
                        end else begin
                            n_timer[i] = r_timer[i] - 16'd1;
                        end
                    end
                end
                unique case (r_in.opcode)
                    OPC_LOAD: begin
                        n_mrd = 1'b1;
                        n_addr = r_opa + bval;
                        n_ld_pend = 1'b1;
                        n_ld_target = r_in.dest_reg;
                        n_ld_thread = r_cur;
                        n_idle[r_cur] = 1'b1;
                        n_timer[r_cur] = r_load_lat;
                    end
                    OPC_STORE: begin
                        n_mwr = 1'b1;
                        n_addr = r_opa + bval;
                        n_wdata = rf_out;
                        n_idle[r_cur] = 1'b1;
                        n_timer[r_cur] = r_store_lat;
                    end
                    OPC_HALT: begin
                        n_halted[r_cur] = 1'b1;
                        n_idle[r_cur] = 1'b1;
                        n_timer[r_cur] = 16'd0;
                    end
                    default: ;
                endcase
            end
            DP_SCH_MIN: begin
                // Halted threads count as idle; find the least running timer.
                n_all_idle = 1'b1;
                n_least = 16'hFFFF;
                for (int i = 0; i < THREADS_MAX; i++) begin
                    if (i < int'(live_n)) begin
                        if (r_halted[i]) n_idle[i] = 1'b1;
                        if (!n_idle[i]) n_all_idle = 1'b0;
                        if (!r_halted[i] && r_timer[i] < n_least) n_least = r_timer[i];
                    end
                end
                n_skip = every_halted;
            end
            DP_SCH_PICK: begin
                if (!r_skip && r_all_idle) begin
                    // Every thread waits: pick among those with the least timer.
                    if (r_policy) begin
                        for (int i = 0; i < THREADS_MAX; i++) begin
                            cand = i < int'(live_n) && !r_halted[i] && r_timer[i] == r_least;
                            if (cand && (!found || r_last[i] > r_last[pick])) pick = 3'(i);
                            found = found | cand;
                        end
                    end else begin
                        for (int i = 0; i < THREADS_MAX; i++) begin
                            if (!found && i > int'(r_cur) && i < int'(live_n) &&
                                !r_halted[i] && r_timer[i] == r_least) begin
                                pick = 3'(i); found = 1'b1;
                            end
                        end
                        for (int i = 0; i < THREADS_MAX; i++) begin
                            if (!found && i <= int'(r_cur) && i < int'(live_n) &&
                                !r_halted[i] && r_timer[i] == r_least) begin
                                pick = 3'(i); found = 1'b1;
                            end
                        end
                    end
                    if (!found) pick = 3'd0;
                    // Skip time ahead by the least timer.
                    for (int i = 0; i < THREADS_MAX; i++) begin
                        if (i < int'(live_n) && !r_halted[i]) begin
                            diff = r_timer[i] - r_least;
                            n_timer[i] = diff;
                            if (diff == 16'd0) n_idle[i] = 1'b0;
                        end
                    end
                    n_cyc = r_cyc + 32'(r_least);
                    n_next = pick;
                end else if (!r_skip) begin
                    // Round robin over ready threads, starting after the current one and wrapping around.
                    for (int i = 0; i < THREADS_MAX; i++) begin
                        if (!found && i > int'(r_cur) && i < int'(live_n) && !r_idle[i]) begin
                            pick = 3'(i); found = 1'b1;
                        end
                    end
                    for (int i = 0; i < THREADS_MAX; i++) begin
                        if (!found && i < int'(live_n) && !r_idle[i] &&
                            (!r_policy || i < int'(r_cur))) begin
                            pick = 3'(i); found = 1'b1;
                        end
                    end
                    n_next = pick;
                end
            end
            DP_SCH_SWITCH: begin
                if (!r_skip) begin
                    // Blocked policy charges the overhead on a thread change.
                    if (r_policy && r_next != r_cur) begin
                        n_cyc = r_cyc + 32'(r_switch_ovh);
                        for (int i = 0; i < THREADS_MAX; i++) begin
                            if (i < int'(live_n) && !r_halted[i]) begin
                                if (r_switch_ovh >= r_timer[i]) begin
                                    n_timer[i] = 16'd0;
                                    n_idle[i]  = 1'b0;
                                end else begin
                                    n_timer[i] = r_timer[i] - r_switch_ovh;
                                end
                            end
                        end
                    end
                    n_cur = r_next;
                end
            end
            DP_LOAD_RET: n_ld_pend = 1'b0;
            DP_FIN: begin
                n_out.fetch_ready       = !every_halted;
                n_out.next_thread       = every_halted ? 3'd0 : r_cur;
                n_out.next_pc           = every_halted ? 32'd0 : r_pc[r_cur];
                n_out.mem_read          = r_mrd;
                n_out.mem_write         = r_mwr;
                n_out.mem_address       = r_addr;
                n_out.mem_write_data    = r_wdata;
                n_out.read_data         = (r_in.mode == MODE_CTX_READ &&
                                           {1'b0, r_in.query_thread} < live_n) ? rf_out
                                                                               : 32'd0;
                n_out.cycle_count       = r_cyc;
                n_out.instruction_count = r_inst;
                n_out.all_halted        = every_halted;
            end
            default: ;
        endcase
        // Result register: loaded at the end of an item, emptied when taken.
        if (i_cmd.op == DP_FIN) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < THREADS_MAX; i++) begin
                r_pc[i]    <= 32'd0;
                r_timer[i] <= 16'd0;
                r_last[i]  <= 32'd0;
            end
            r_idle <= '0; r_halted <= '0; r_cur <= 3'd0; r_next <= 3'd0;
            r_cyc <= 32'd0; r_inst <= 32'd0; r_ld_pend <= 1'b0;
            r_ld_target <= 3'd0; r_ld_thread <= 3'd0;
            r_all_idle <= 1'b0; r_skip <= 1'b0; r_least <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc; r_timer <= n_timer; r_last <= n_last;
            r_idle <= n_idle; r_halted <= n_halted; r_cur <= n_cur; r_next <= n_next;
            r_cyc <= n_cyc; r_inst <= n_inst; r_ld_pend <= n_ld_pend;
            r_ld_target <= n_ld_target; r_ld_thread <= n_ld_thread;
            r_all_idle <= n_all_idle; r_skip <= n_skip; r_least <= n_least;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_in <= n_in; r_opa <= n_opa; r_opb <= n_opb;
        r_mrd <= n_mrd; r_mwr <= n_mwr; r_addr <= n_addr; r_wdata <= n_wdata;
        r_out <= n_out;
    end

    // Status toward the controller.
    assign o_status = '{
        all_halted: every_halted,
        need_sched: !r_policy || r_in.opcode == OPC_LOAD ||
                    r_in.opcode == OPC_STORE || r_in.opcode == OPC_HALT,
        out_busy:   r_out_valid && i_out_stall
    };
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

@@ rtl/core/mts_ctrl.sv @@
// Controller state machine of the scheduler: sequences the datapath per item.
// Depends on mts_pkg; talks to mts_datapath through t_dp_cmd and t_dp_status.
module mts_ctrl import mts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_mode,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath command.
    always_comb begin
        n_state    = r_state;
        o_cmd.op   = DP_NONE;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_LATCH;
                    priority if (i_mode == MODE_INSTR && !i_status.all_halted) begin
                        n_state = S_RD_A;
                    end else if (i_mode == MODE_LOAD_RET) begin
                        n_state = S_LOAD_RET;
                    end else if (i_mode == MODE_CTX_READ) begin
                        n_state = S_CTX;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_RD_A:       begin o_cmd.op = DP_RD_A; n_state = S_RD_B; end
            S_RD_B:       begin o_cmd.op = DP_RD_B; n_state = S_RD_C; end
            S_RD_C:       begin o_cmd.op = DP_RD_C; n_state = S_EXEC; end
            S_EXEC: begin
                o_cmd.op = DP_EXEC;
                n_state  = i_status.need_sched ? S_SCH_MIN : S_FIN;
            end
            S_SCH_MIN:    begin o_cmd.op = DP_SCH_MIN;    n_state = S_SCH_PICK; end
            S_SCH_PICK:   begin o_cmd.op = DP_SCH_PICK;   n_state = S_SCH_SWITCH; end
            S_SCH_SWITCH: begin o_cmd.op = DP_SCH_SWITCH; n_state = S_FIN; end
            S_LOAD_RET:   begin o_cmd.op = DP_LOAD_RET;   n_state = S_FIN; end
            S_CTX:        begin o_cmd.op = DP_CTX;        n_state = S_FIN; end
            S_FIN: begin
                // Wait until the result register is free.
                if (!i_status.out_busy) begin
                    o_cmd.op = DP_FIN;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ rtl/core/multithread_core_thread_scheduler.sv @@
// Multithreaded core scheduler: eight thread contexts, fine-grained or blocked switching.
// Input beats on i_item (i_in_valid / o_in_stall), one result beat per input beat on
// o_result (o_out_valid / i_out_stall). A beat moves when valid is high and stall low.
// The user must write the configuration through i_cfg_we, i_cfg_index and i_cfg_data
// only while idle; the block itself does not enforce this. An instruction passes three
// operand reads in turn through the one-port register file, the execute step and, where
// it reschedules, the three scheduling steps: minimum search, thread pick, switch charge.
// A load return or context read passes its own step; an ignored item goes straight to
// the final step. A new item is taken in the idle state after the previous one has
// reached the result register, so items are worked one at a time.
// When the receiver stalls, the finished result holds and the next item may already
// be accepted and worked; it waits only to enter the result register.
// Reset (synchronous, active low) clears all contexts, counters and timers and restores
// the configuration defaults; the register file reads zero until written.
`include "multithread_core_thread_scheduler_defines.svh"
module multithread_core_thread_scheduler import mts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_item       i_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_res        o_result,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencer.
    mts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_item.mode),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Contexts, register file and result register.
    mts_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // An accepted beat keeps the sequencer busy in the following cycle.
    `MTS_ASSERT_NXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    // A fully halted core offers no fetch.
    `MTS_ASSERT_IMP(a_halt_no_fetch, o_out_valid && o_result.all_halted, !o_result.fetch_ready)
    // A result never carries both a load and a store.
    `MTS_ASSERT_IMP(a_one_access, o_out_valid, !(o_result.mem_read && o_result.mem_write))

endmodule
